[rtl/rls_pkg.sv]
// Package for the reversible LIFO stack: defaults, operation and status codes, cell control.
`default_nettype none

package rls_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_PUSH    = 3'd0;
    localparam logic [FUNC_W-1:0] OP_POP     = 3'd1;
    localparam logic [FUNC_W-1:0] OP_PEEK    = 3'd2;
    localparam logic [FUNC_W-1:0] OP_BOTTOM  = 3'd3;
    localparam logic [FUNC_W-1:0] OP_REVERSE = 3'd4;
    localparam logic [FUNC_W-1:0] OP_CLEAR   = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic shift_r;  // take the word of the lower-index neighbour
        logic shift_l;  // take the word of the higher-index neighbour
        logic wr;       // write wr_data if this cell matches wr_pos
    } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/rls_cell.sv]
// One storage cell of the stack chain: holds one word, shifts either way or loads locally.
`default_nettype none

module rls_cell
    import rls_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int IDX_W      = 4,
    parameter int IDX        = 0
)
(
    input  wire logic                  clk,
    input  wire cell_ctl_t             ctl,
    input  wire logic [IDX_W-1:0]      wr_pos,
    input  wire logic [DATA_WIDTH-1:0] left_in,
    input  wire logic [DATA_WIDTH-1:0] right_in,
    input  wire logic [DATA_WIDTH-1:0] wr_data,
    output logic      [DATA_WIDTH-1:0] q
);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctl.shift_r)
        begin
            word_next = left_in;
        end
        else if (ctl.shift_l)
        begin
            word_next = right_in;
        end
        else if (ctl.wr && (wr_pos == IDX_W'(IDX)))
        begin
            word_next = wr_data;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

`default_nettype wire

[rtl/reversible_lifo_stack.sv]
// Top level of the reversible LIFO stack: control, fill count and the chain of cells.
`default_nettype none

// Reversible LIFO stack of DEPTH signed words.
//
// Request side: func and data_in are taken at a rising edge with start high
// and busy low. Operations: push, pop, peek, insert at bottom, reverse, clear.
// Result side: done is high for exactly one cycle, the cycle after the
// request was taken, with data_out (popped or peeked word, else zero),
// status (ok, empty, full) and occupancy (count after the request).
// The receiver cannot stall; a result must be taken in its done cycle.
//
// Storage is a row of DEPTH cells, each handing its word to a neighbour.
// Normal order: contents sit at cells 0..n-1, top in cell 0. Reversed order:
// contents sit at the far end, top in cell DEPTH-1. Push and pop shift the
// whole row one cell; bottom insert loads the one cell next to the bottom.
// Throughput: one item per cycle for every operation but reverse.
// Reverse flips the order flag and then slides the contents to the other
// end, one cell per cycle, with busy high while it slides (no slide when
// empty or full). The result of a reverse still comes in the cycle after
// it is taken.
// Reset: stack empty, normal order, no result pending. Stored words are not
// cleared; empty cells are never read.

module reversible_lifo_stack
    import rls_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [FUNC_W-1:0]            func,
    input  wire logic signed [DATA_WIDTH-1:0] data_in,
    output logic                              done,
    output logic signed [DATA_WIDTH-1:0]      data_out,
    output logic [STATUS_W-1:0]               status,
    output logic [$clog2(DEPTH+1)-1:0]        occupancy
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // control state
    logic [CNT_W-1:0]      count_reg,   count_next;
    logic                  rev_reg,     rev_next;
    logic [CNT_W-1:0]      slide_reg,   slide_next;   // realignment shifts left
    logic                  done_reg,    done_next;
    logic [DATA_WIDTH-1:0] dout_reg,    dout_next;
    logic [STATUS_W-1:0]   status_reg,  status_next;

    cell_ctl_t             ctl;
    logic [IDX_W-1:0]      wr_pos;
    logic [CNT_W-1:0]      bottom_pos;
    logic [DATA_WIDTH-1:0] cell_q [DEPTH];
    logic [DATA_WIDTH-1:0] top_word;
    logic                  accept;
    logic                  full;
    logic                  empty;

    assign busy   = (slide_reg != '0);
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    // top sits at one end of the row or the other
    assign top_word = rev_reg ? cell_q[DEPTH-1] : cell_q[0];

    // slot just past the bottom; only used when not full
    assign bottom_pos = rev_reg ? (CNT_W'(DEPTH - 1) - count_reg) : count_reg;
    assign wr_pos     = bottom_pos[IDX_W-1:0];

    always_comb
    begin
        count_next  = count_reg;
        rev_next    = rev_reg;
        slide_next  = slide_reg;
        done_next   = 1'b0;
        dout_next   = '0;
        status_next = ST_OK;
        ctl         = '0;

        if (busy)
        begin
            // slide contents towards the end that now holds the top
            ctl.shift_r = rev_reg;
            ctl.shift_l = !rev_reg;
            slide_next  = slide_reg - CNT_W'(1);
        end
        else if (start)
        begin
            done_next = 1'b1;
            unique case (func) inside
                OP_PUSH:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctl.shift_r = !rev_reg;
                        ctl.shift_l = rev_reg;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                OP_POP, OP_PEEK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        dout_next = top_word;
                        if (func == OP_POP)
                        begin
                            ctl.shift_r = rev_reg;
                            ctl.shift_l = !rev_reg;
                            count_next  = count_reg - CNT_W'(1);
                        end
                    end
                end
                OP_BOTTOM:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctl.wr     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_REVERSE:
                begin
                    rev_next   = !rev_reg;
                    slide_next = empty ? '0 : (CNT_W'(DEPTH) - count_reg);
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                    rev_next   = 1'b0;
                    slide_next = '0;
                end
                default:
                begin
                    // unused codes: no operation
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rev_reg   <= 1'b0;
            slide_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rev_reg   <= rev_next;
            slide_reg <= slide_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dout_reg   <= dout_next;
            status_reg <= status_next;
        end
    end

    // the row of cells; the end cells take data_in from outside
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_in;
        logic [DATA_WIDTH-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = data_in;
        end
        else
        begin : g_mid_l
            assign left_in = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = data_in;
        end
        else
        begin : g_mid_r
            assign right_in = cell_q[i+1];
        end

        rls_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .IDX        (i)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .wr_pos   (wr_pos),
            .left_in  (left_in),
            .right_in (right_in),
            .wr_data  (data_in),
            .q        (cell_q[i])
        );
    end

    assign done      = done_reg;
    assign data_out  = dout_reg;
    assign status    = status_reg;
    assign occupancy = count_reg;

endmodule

`default_nettype wire

[rtl/rls_checker.sv]
// Port-level checker for the reversible LIFO stack, bound to the top level.
`default_nettype none

module rls_checker
    import rls_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         done,
    input wire logic signed [DATA_WIDTH-1:0] data_out,
    input wire logic [STATUS_W-1:0]          status,
    input wire logic [$clog2(DEPTH+1)-1:0]   occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // one result for every item taken, in the following cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("no result after an accepted item");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without an accepted item");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (occupancy == CNT_W'(DEPTH)))
        else $error("full status while not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (occupancy == '0 && data_out == '0))
        else $error("empty status with words stored or data returned");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= CNT_W'(DEPTH))
        else $error("occupancy beyond depth");

endmodule

bind reversible_lifo_stack rls_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_rls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .data_out  (data_out),
    .status    (status),
    .occupancy (occupancy)
);

`default_nettype wire

[sim/rls_checker.sv]
// Checker for the reversible LIFO stack: shadow stack, expected replies and field compare.
`timescale 1ns / 1ps

module rls_tb_checker
    import rls_pkg::*;
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic                                  busy,
    input  wire logic [FUNC_W-1:0]                     func,
    input  wire logic signed [DATA_WIDTH_DEF-1:0]      data_in,
    input  wire logic                                  done,
    input  wire logic signed [DATA_WIDTH_DEF-1:0]      data_out,
    input  wire logic [STATUS_W-1:0]                   status,
    input  wire logic [$clog2(DEPTH_DEF+1)-1:0]        occupancy,
    output int                                         error_count,
    output int                                         results_owed
);

    localparam int DW     = DATA_WIDTH_DEF;
    localparam int SLOT_W = $clog2(DEPTH_DEF);
    localparam int OCC_W  = $clog2(DEPTH_DEF + 1);

    typedef struct {
        logic signed [DW-1:0] word;
        logic [STATUS_W-1:0]  code;
        logic [OCC_W-1:0]     count;
    } reply_t;

    // shadow of the stack: circular store, top slot, fill and growth direction
    logic signed [DW-1:0] shadow_words [DEPTH_DEF];
    logic [SLOT_W-1:0]    top_slot;
    logic [OCC_W-1:0]     word_count;
    logic                 grows_back;

    reply_t replies_due[$];

    // slot k steps from the top, towards the bottom or away from it
    function automatic logic [SLOT_W-1:0] slot_from(input logic [SLOT_W-1:0] k,
                                                    input logic toward_bottom);
        if (toward_bottom != grows_back)
            return top_slot - k;
        return top_slot + k;
    endfunction

    task automatic run_request(input logic [FUNC_W-1:0] op,
                               input logic signed [DW-1:0] word,
                               output reply_t reply);
        logic [SLOT_W-1:0] s;
        reply.word = '0;
        reply.code = ST_OK;
        case (op) inside
            OP_PUSH:
                if (word_count >= DEPTH_DEF)
                    reply.code = ST_FULL;
                else
                begin
                    s = (word_count == 0) ? top_slot : slot_from(SLOT_W'(1), 1'b0);
                    shadow_words[s] = word;
                    top_slot = s;
                    word_count++;
                end
            OP_POP, OP_PEEK:
                if (word_count == 0)
                    reply.code = ST_EMPTY;
                else
                begin
                    reply.word = shadow_words[top_slot];
                    if (op == OP_POP)
                    begin
                        word_count--;
                        if (word_count != 0)
                            top_slot = slot_from(SLOT_W'(1), 1'b1);
                    end
                end
            OP_BOTTOM:
                if (word_count >= DEPTH_DEF)
                    reply.code = ST_FULL;
                else
                begin
                    s = slot_from(word_count[SLOT_W-1:0], 1'b1);
                    shadow_words[s] = word;
                    word_count++;
                end
            OP_REVERSE:
            begin
                if (word_count != 0)
                    top_slot = slot_from(SLOT_W'(word_count - 1), 1'b1);
                grows_back = !grows_back;
            end
            OP_CLEAR:
            begin
                word_count = '0;
                top_slot   = '0;
                grows_back = 1'b0;
            end
            default:
                ;
        endcase
        reply.count = word_count;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t fresh;
        reply_t oldest;
        if (!rst_n)
        begin
            word_count = '0;
            top_slot   = '0;
            grows_back = 1'b0;
            replies_due.delete();
            results_owed <= 0;
        end
        else
        begin
            if (done)
            begin
                if (replies_due.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result: data_out %0d status %0d occupancy %0d",
                             $time, data_out, status, occupancy);
                end
                else
                begin
                    oldest = replies_due.pop_front();
                    if (data_out !== oldest.word)
                    begin
                        error_count++;
                        $display("%0t: data_out expected %0d actual %0d",
                                 $time, oldest.word, data_out);
                    end
                    if (status !== oldest.code)
                    begin
                        error_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, oldest.code, status);
                    end
                    if (occupancy !== oldest.count)
                    begin
                        error_count++;
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, oldest.count, occupancy);
                    end
                end
            end
            if (start && !busy)
            begin
                run_request(func, data_in, fresh);
                replies_due.push_back(fresh);
            end
            results_owed <= replies_due.size();
        end
    end

endmodule

[sim/tb_top.sv]
// Top of the reversible LIFO stack testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import rls_pkg::*;

    localparam int DW    = DATA_WIDTH_DEF;
    localparam int OCC_W = $clog2(DEPTH_DEF + 1);

    // func codes with no operation behind them; the stack must leave itself alone
    localparam logic [FUNC_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [FUNC_W-1:0] OP_SPARE_B = 3'd7;

    localparam int RANDOM_ITEMS = 600;
    // a reverse may go on sliding the row after its reply
    localparam int SETTLE_CYCLES = DEPTH_DEF + 4;

    // flavour of a random stretch: mostly growing, mostly shrinking, or anything
    typedef enum int {FILL_UP, DRAIN, CHURN} mood_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [FUNC_W-1:0]          func;
    logic signed [DW-1:0]       data_in;
    logic                       done;
    logic signed [DW-1:0]       data_out;
    logic [STATUS_W-1:0]        status;
    logic [OCC_W-1:0]           occupancy;
    int                         error_count;
    int                         results_owed;

    // set for stretches where the sender never idles between items
    bit steady_feed;

    reversible_lifo_stack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .data_in   (data_in),
        .done      (done),
        .data_out  (data_out),
        .status    (status),
        .occupancy (occupancy)
    );

    rls_tb_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .data_in      (data_in),
        .done         (done),
        .data_out     (data_out),
        .status       (status),
        .occupancy    (occupancy),
        .error_count  (error_count),
        .results_owed (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Present one item and hold it until the stack takes it. An optional gap
    // of idle cycles goes first; with no gap start simply stays high, so
    // start never sees two assignments in one step.
    task automatic send_request(input logic [FUNC_W-1:0] op, input logic signed [DW-1:0] word);
        int gap;
        gap = steady_feed ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        func    <= op;
        data_in <= word;
        // accepted at the first edge that finds busy low
        do
            @(posedge clk);
        while (busy);
    endtask

    // Sender holds off until every reply owed has come back. The first edge
    // lets the checker count an item taken in this very step.
    task automatic wait_for_results;
        start <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // Mostly random words, with the extremes showing up now and then
    function automatic logic signed [DW-1:0] pick_word;
        case ($urandom_range(0, 15))
            0:       return {1'b1, {(DW-1){1'b0}}};
            1:       return {1'b0, {(DW-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return DW'($urandom);
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_op(input mood_t mood);
        int r;
        r = $urandom_range(0, 99);
        case (mood)
            FILL_UP:
                if (r < 45)      return OP_PUSH;
                else if (r < 75) return OP_BOTTOM;
                else if (r < 85) return OP_POP;
                else if (r < 90) return OP_PEEK;
                else if (r < 96) return OP_REVERSE;
                else if (r < 98) return OP_SPARE_A;
                else             return OP_SPARE_B;
            DRAIN:
                if (r < 50)      return OP_POP;
                else if (r < 65) return OP_PEEK;
                else if (r < 78) return OP_PUSH;
                else if (r < 85) return OP_REVERSE;
                else if (r < 90) return OP_BOTTOM;
                else if (r < 94) return OP_CLEAR;
                else if (r < 97) return OP_SPARE_A;
                else             return OP_SPARE_B;
            default:
                if (r < 22)      return OP_PUSH;
                else if (r < 40) return OP_POP;
                else if (r < 52) return OP_PEEK;
                else if (r < 66) return OP_BOTTOM;
                else if (r < 78) return OP_REVERSE;
                else if (r < 84) return OP_CLEAR;
                else if (r < 92) return OP_SPARE_A;
                else             return OP_SPARE_B;
        endcase
    endfunction

    initial
    begin
        int    sent;
        int    stretch;
        mood_t mood;

        rst_n       = 1'b0;
        start       = 1'b0;
        func        = OP_PUSH;
        data_in     = '0;
        steady_feed = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-stack cases first (pop, peek, reverse on nothing)
        send_request(OP_POP, pick_word());
        send_request(OP_PEEK, pick_word());
        send_request(OP_REVERSE, pick_word());
        // extremes of the word, top and bottom ends, a reverse with content
        send_request(OP_PUSH, {1'b0, {(DW-1){1'b1}}});
        send_request(OP_BOTTOM, {1'b1, {(DW-1){1'b0}}});
        send_request(OP_PEEK, '0);
        send_request(OP_REVERSE, '1);
        send_request(OP_POP, '0);
        // spare codes: no effect, reply ok with the count unchanged
        send_request(OP_SPARE_A, '1);
        send_request(OP_SPARE_B, '1);
        send_request(OP_POP, '0);
        send_request(OP_POP, '0);
        // fill to the brim from both ends, then push and insert when full
        for (int i = 0; i < DEPTH_DEF; i++)
            send_request(i[0] ? OP_BOTTOM : OP_PUSH, pick_word());
        send_request(OP_PUSH, '1);
        send_request(OP_BOTTOM, '1);
        send_request(OP_REVERSE, '0);
        send_request(OP_CLEAR, '0);

        // sender holds off until every reply is in
        wait_for_results;

        // Random stretches with a mood each; some run without any gaps
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mood        = mood_t'($urandom_range(0, 2));
            stretch     = $urandom_range(10, 50);
            steady_feed = ($urandom_range(0, 3) == 0);
            repeat (stretch)
            begin
                send_request(pick_op(mood), pick_word());
                sent++;
            end
            if ($urandom_range(0, 2) == 0)
                wait_for_results;
        end

        wait_for_results;
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #500_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
